@@ hw/rtl/ssx_pkg.sv @@
// shared types, codes and constants of the shadow silhouette extruder
`default_nettype none

package ssx_pkg;

	// default table depths
	localparam int unsigned POINT_DEPTH_DEF = 256;
	localparam int unsigned PLANE_DEPTH_DEF = 256;

	// field widths
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// request codes
	localparam logic [1:0] REQ_VERTEX = 2'd0;
	localparam logic [1:0] REQ_PLANE  = 2'd1;
	localparam logic [1:0] REQ_EDGE   = 2'd2;

	// back face kinds; any other kind behaves as an open edge
	localparam logic [1:0] BACK_PAIRED = 2'd0;
	localparam logic [1:0] BACK_TOP    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_W = 3'd3;

	// point light at the origin after reset
	localparam logic signed [VAL_W-1:0] LIGHT_W_RESET = 32'sh0001_0000;

	typedef logic signed [VAL_W-1:0] val_t;

	// exact sum of two Q32.32 products
	typedef logic signed [2*VAL_W:0] dist_t;

	typedef struct packed {
		val_t x;
		val_t y;
		val_t z;
	} vec_t;

	typedef struct packed {
		val_t a;
		val_t b;
		val_t c;
		val_t d;
	} plane_t;

	typedef struct packed {
		val_t x;
		val_t y;
		val_t z;
		val_t w;
	} light_t;

	// control traveling with an edge through the pipeline
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
	} ctl_t;

	// table data of one edge: front plane, back plane, vertex a, vertex b
	typedef struct packed {
		plane_t pl0;
		plane_t pl1;
		vec_t   v0;
		vec_t   v1;
	} fetch_t;

	// partial plane distances and both vertices, local and extruded
	typedef struct packed {
		dist_t d0a;
		dist_t d0b;
		dist_t d1a;
		dist_t d1b;
		vec_t  loc0;
		vec_t  loc1;
		vec_t  far0;
		vec_t  far1;
	} sum_t;

endpackage

`default_nettype wire

@@ hw/rtl/shadow_silhouette_extrude.sv @@
// Shadow volume silhouette extruder, top level.
//
// Input channel (in_valid / in_stall) carries vertex loads, plane loads and
// edges; a load is one transfer and fills one entry of the vertex or plane
// table, which must be written before any edge reads it.
// Output channel (out_valid / out_stall) carries the vertices of each
// silhouette edge: two local vertices (finite high) and then the same two
// extruded to infinity, last_of_run marking the fourth.
// The light sits in four registers on the cfg_wr_* port; they must be
// written only while the block is idle, which the block itself does not enforce.
// The first vertex of an edge passes the table read, stage 2, stage 3 and
// the quad register. Loads and non-silhouette edges go at one per cycle
// while in_stall is low; silhouette edges are paced by the single output
// channel that carries four vertices per edge.
// Reset clears the pipeline and sets the light to a point at the origin
// (w = 1.0); the tables keep no reset value.
// When the receiver stalls, the quad in flight holds and the pipeline
// fills behind it; in_stall rises once a finished edge waits for the
// output sequencer.
`default_nettype none

module shadow_silhouette_extrude #(
	parameter int unsigned POINT_DEPTH = ssx_pkg::POINT_DEPTH_DEF,
	parameter int unsigned PLANE_DEPTH = ssx_pkg::PLANE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [ssx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ssx_pkg::VAL_W-1:0]       cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      req_type,
	input  wire logic [ssx_pkg::IDX_W-1:0]       entry_index,
	input  wire logic signed [ssx_pkg::VAL_W-1:0] val_a,
	input  wire logic signed [ssx_pkg::VAL_W-1:0] val_b,
	input  wire logic signed [ssx_pkg::VAL_W-1:0] val_c,
	input  wire logic signed [ssx_pkg::VAL_W-1:0] val_d,
	input  wire logic [ssx_pkg::IDX_W-1:0]       vert_a,
	input  wire logic [ssx_pkg::IDX_W-1:0]       vert_b,
	input  wire logic [ssx_pkg::IDX_W-1:0]       face_a,
	input  wire logic [ssx_pkg::IDX_W-1:0]       face_b,
	input  wire logic [1:0]                      back_kind,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [ssx_pkg::VAL_W-1:0]     out_x,
	output logic signed [ssx_pkg::VAL_W-1:0]     out_y,
	output logic signed [ssx_pkg::VAL_W-1:0]     out_z,
	output logic                                 finite,
	output logic                                 last_of_run
);

	import ssx_pkg::*;

	light_t light_q;
	logic   hold;
	logic   adv;
	ctl_t   s1_ctl;
	fetch_t s1_data;
	ctl_t   s3_ctl;
	sum_t   s3_data;

	// light registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q.x <= '0;
			light_q.y <= '0;
			light_q.z <= '0;
			light_q.w <= LIGHT_W_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LIGHT_X: light_q.x <= cfg_wr_data;
				CFG_LIGHT_Y: light_q.y <= cfg_wr_data;
				CFG_LIGHT_Z: light_q.z <= cfg_wr_data;
				CFG_LIGHT_W: light_q.w <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	// whole pipeline moves unless a finished edge waits for the sequencer
	assign adv      = !hold;
	assign in_stall = hold;

	ssx_fetch #(
		.POINT_DEPTH (POINT_DEPTH),
		.PLANE_DEPTH (PLANE_DEPTH)
	) u_fetch (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (in_valid),
		.req_type    (req_type),
		.entry_index (entry_index),
		.val_a       (val_a),
		.val_b       (val_b),
		.val_c       (val_c),
		.val_d       (val_d),
		.vert_a      (vert_a),
		.vert_b      (vert_b),
		.face_a      (face_a),
		.face_b      (face_b),
		.back_kind   (back_kind),
		.s1_ctl      (s1_ctl),
		.s1_data     (s1_data)
	);

	ssx_math u_math (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.light   (light_q),
		.s1_ctl  (s1_ctl),
		.s1_data (s1_data),
		.s3_ctl  (s3_ctl),
		.s3_data (s3_data)
	);

	ssx_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.s3_ctl      (s3_ctl),
		.s3_data     (s3_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.finite      (finite),
		.last_of_run (last_of_run),
		.hold        (hold)
	);

endmodule

`default_nettype wire

@@ hw/rtl/ssx_ram.sv @@
// generic ram: one write port, two registered read ports
`default_nettype none

module ssx_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr0,
	input  wire logic [AW-1:0]    raddr1,
	output logic      [WIDTH-1:0] rdata0,
	output logic      [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ssx_fetch.sv @@
// table loads and edge lookups, first pipeline stage
`default_nettype none

module ssx_fetch #(
	parameter int unsigned POINT_DEPTH = ssx_pkg::POINT_DEPTH_DEF,
	parameter int unsigned PLANE_DEPTH = ssx_pkg::PLANE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire logic [1:0]                   req_type,
	input  wire logic [ssx_pkg::IDX_W-1:0]    entry_index,
	input  wire ssx_pkg::val_t                val_a,
	input  wire ssx_pkg::val_t                val_b,
	input  wire ssx_pkg::val_t                val_c,
	input  wire ssx_pkg::val_t                val_d,
	input  wire logic [ssx_pkg::IDX_W-1:0]    vert_a,
	input  wire logic [ssx_pkg::IDX_W-1:0]    vert_b,
	input  wire logic [ssx_pkg::IDX_W-1:0]    face_a,
	input  wire logic [ssx_pkg::IDX_W-1:0]    face_b,
	input  wire logic [1:0]                   back_kind,
	output ssx_pkg::ctl_t                     s1_ctl,
	output ssx_pkg::fetch_t                   s1_data
);

	import ssx_pkg::*;

	localparam int unsigned IDX_N = 2 ** IDX_W;
	localparam int unsigned PT_AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
	localparam int unsigned PL_AW = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
	localparam int unsigned PT_W  = 3 * VAL_W;
	localparam int unsigned PL_W  = 4 * VAL_W;

	logic [PT_AW-1:0] pt_mod [IDX_N];
	logic [PL_AW-1:0] pl_mod [IDX_N];
	logic             accept;
	logic             pt_we;
	logic             pl_we;
	logic             rd_en;
	logic [PT_W-1:0]  pt_rd0;
	logic [PT_W-1:0]  pt_rd1;
	logic [PL_W-1:0]  pl_rd0;
	logic [PL_W-1:0]  pl_rd1;
	ctl_t             ctl_s1;

	// index wrap tables, worked out at elaboration
	for (genvar gi = 0; gi < IDX_N; gi++) begin : g_mod
		assign pt_mod[gi] = PT_AW'(gi % POINT_DEPTH);
		assign pl_mod[gi] = PL_AW'(gi % PLANE_DEPTH);
	end

	// request decode on transfer
	assign accept = in_valid && adv;
	assign pt_we  = accept && (req_type == REQ_VERTEX);
	assign pl_we  = accept && (req_type == REQ_PLANE);
	assign rd_en  = accept && (req_type == REQ_EDGE);

	// vertex table, x y z packed
	ssx_ram #(
		.WIDTH (PT_W),
		.DEPTH (POINT_DEPTH)
	) u_point_ram (
		.clk    (clk),
		.we     (pt_we),
		.waddr  (pt_mod[entry_index]),
		.wdata  ({val_a, val_b, val_c}),
		.re     (rd_en),
		.raddr0 (pt_mod[vert_a]),
		.raddr1 (pt_mod[vert_b]),
		.rdata0 (pt_rd0),
		.rdata1 (pt_rd1)
	);

	// plane table, a b c d packed
	ssx_ram #(
		.WIDTH (PL_W),
		.DEPTH (PLANE_DEPTH)
	) u_plane_ram (
		.clk    (clk),
		.we     (pl_we),
		.waddr  (pl_mod[entry_index]),
		.wdata  ({val_a, val_b, val_c, val_d}),
		.re     (rd_en),
		.raddr0 (pl_mod[face_a]),
		.raddr1 (pl_mod[face_b]),
		.rdata0 (pl_rd0),
		.rdata1 (pl_rd1)
	);

	// edge control alongside the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= rd_en;
			ctl_s1.kind  <= back_kind;
		end
	end

	assign s1_ctl       = ctl_s1;
	assign s1_data.pl0  = plane_t'(pl_rd0);
	assign s1_data.pl1  = plane_t'(pl_rd1);
	assign s1_data.v0   = vec_t'(pt_rd0);
	assign s1_data.v1   = vec_t'(pt_rd1);

endmodule

`default_nettype wire

@@ hw/rtl/ssx_math.sv @@
// plane distance products and sums, vertex extrusion
`default_nettype none

module ssx_math (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire ssx_pkg::light_t light,
	input  wire ssx_pkg::ctl_t   s1_ctl,
	input  wire ssx_pkg::fetch_t s1_data,
	output ssx_pkg::ctl_t        s3_ctl,
	output ssx_pkg::sum_t        s3_data
);

	import ssx_pkg::*;

	localparam int unsigned PW = 2 * VAL_W;
	localparam int unsigned QW = PW - 16 + 1;
	localparam val_t SAT_MAX = 32'sh7FFF_FFFF;
	localparam val_t SAT_MIN = 32'sh8000_0000;

	typedef logic signed [PW-1:0] prod_t;

	// floor(p / 2^16) - l, clamped to 32 bits
	function automatic val_t extrude(input prod_t p, input val_t l);
		logic signed [QW-1:0] q;
		q = QW'($signed(p[PW-1:16])) - QW'(l);
		if ((&q[QW-1:VAL_W-1]) || !(|q[QW-1:VAL_W-1])) begin
			return q[VAL_W-1:0];
		end
		return q[QW-1] ? SAT_MIN : SAT_MAX;
	endfunction

	prod_t pl0_prod [4];
	prod_t pl1_prod [4];
	prod_t v0_prod  [3];
	prod_t v1_prod  [3];
	prod_t pl0_s2   [4];
	prod_t pl1_s2   [4];
	prod_t v0_s2    [3];
	prod_t v1_s2    [3];
	vec_t  loc0_s2;
	vec_t  loc1_s2;
	ctl_t  ctl_s2;
	ctl_t  ctl_s3;
	sum_t  sum_nxt;
	sum_t  sum_s3;

	// products of plane terms with the light, and of vertices with light w
	always_comb begin
		pl0_prod[0] = PW'(s1_data.pl0.a) * PW'(light.x);
		pl0_prod[1] = PW'(s1_data.pl0.b) * PW'(light.y);
		pl0_prod[2] = PW'(s1_data.pl0.c) * PW'(light.z);
		pl0_prod[3] = PW'(s1_data.pl0.d) * PW'(light.w);
		pl1_prod[0] = PW'(s1_data.pl1.a) * PW'(light.x);
		pl1_prod[1] = PW'(s1_data.pl1.b) * PW'(light.y);
		pl1_prod[2] = PW'(s1_data.pl1.c) * PW'(light.z);
		pl1_prod[3] = PW'(s1_data.pl1.d) * PW'(light.w);
		v0_prod[0]  = PW'(s1_data.v0.x) * PW'(light.w);
		v0_prod[1]  = PW'(s1_data.v0.y) * PW'(light.w);
		v0_prod[2]  = PW'(s1_data.v0.z) * PW'(light.w);
		v1_prod[0]  = PW'(s1_data.v1.x) * PW'(light.w);
		v1_prod[1]  = PW'(s1_data.v1.y) * PW'(light.w);
		v1_prod[2]  = PW'(s1_data.v1.z) * PW'(light.w);
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= s1_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl0_s2  <= pl0_prod;
			pl1_s2  <= pl1_prod;
			v0_s2   <= v0_prod;
			v1_s2   <= v1_prod;
			loc0_s2 <= s1_data.v0;
			loc1_s2 <= s1_data.v1;
		end
	end

	// pair sums of the distances and the extruded coordinates
	always_comb begin
		sum_nxt.d0a    = (PW + 1)'(pl0_s2[0]) + (PW + 1)'(pl0_s2[1]);
		sum_nxt.d0b    = (PW + 1)'(pl0_s2[2]) + (PW + 1)'(pl0_s2[3]);
		sum_nxt.d1a    = (PW + 1)'(pl1_s2[0]) + (PW + 1)'(pl1_s2[1]);
		sum_nxt.d1b    = (PW + 1)'(pl1_s2[2]) + (PW + 1)'(pl1_s2[3]);
		sum_nxt.loc0   = loc0_s2;
		sum_nxt.loc1   = loc1_s2;
		sum_nxt.far0.x = extrude(v0_s2[0], light.x);
		sum_nxt.far0.y = extrude(v0_s2[1], light.y);
		sum_nxt.far0.z = extrude(v0_s2[2], light.z);
		sum_nxt.far1.x = extrude(v1_s2[0], light.x);
		sum_nxt.far1.y = extrude(v1_s2[1], light.y);
		sum_nxt.far1.z = extrude(v1_s2[2], light.z);
	end

	// stage 3 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sum_nxt;
		end
	end

	assign s3_ctl  = ctl_s3;
	assign s3_data = sum_s3;

	// a held pipeline keeps its last stage in place
	a_hold_keeps_s3: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_s3))
		else $error("stage 3 control changed while the pipeline was held");

endmodule

`default_nettype wire

@@ hw/rtl/ssx_emit.sv @@
// silhouette decision and four-vertex output sequencer
`default_nettype none

module ssx_emit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ssx_pkg::ctl_t s3_ctl,
	input  wire ssx_pkg::sum_t s3_data,
	input  wire logic          out_stall,
	output logic               out_valid,
	output ssx_pkg::val_t      out_x,
	output ssx_pkg::val_t      out_y,
	output ssx_pkg::val_t      out_z,
	output logic               finite,
	output logic               last_of_run,
	output logic               hold
);

	import ssx_pkg::*;

	localparam int unsigned SW = 2 * VAL_W + 2;
	localparam logic [1:0] BEAT_FIRST     = 2'd0;
	localparam logic [1:0] BEAT_FIRST_FAR = 2'd2;
	localparam logic [1:0] BEAT_LAST      = 2'd3;

	logic signed [SW-1:0] dist0;
	logic signed [SW-1:0] dist1;
	logic                 neg0;
	logic                 zero0;
	logic                 neg1;
	logic                 drop;
	logic                 swap;
	logic                 straight;
	logic                 needs;
	logic                 free;
	logic                 load;
	logic                 valid_q;
	logic [1:0]           cnt_q;
	vec_t                 quad_q [4];
	vec_t                 beat;

	// full plane distances, only their signs and a zero front distance matter
	always_comb begin
		dist0 = SW'(s3_data.d0a) + SW'(s3_data.d0b);
		dist1 = SW'(s3_data.d1a) + SW'(s3_data.d1b);
		neg0  = dist0[SW-1];
		zero0 = (dist0 == '0);
		// open edges face the front distance negated
		neg1  = (s3_ctl.kind == BACK_PAIRED) ? dist1[SW-1] : (!neg0 && !zero0);
		drop  = (s3_ctl.kind == BACK_TOP) && neg0;
		swap     = !neg0 && neg1;
		straight = neg0 && !neg1;
		needs = s3_ctl.valid && !drop && (swap || straight);
	end

	// sequencer takes a quad when empty or on the last transfer of the current one
	assign free = !valid_q || (!out_stall && (cnt_q == BEAT_LAST));
	assign load = needs && free;
	assign hold = needs && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= BEAT_FIRST;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= BEAT_FIRST;
		end else if (valid_q && !out_stall) begin
			if (cnt_q == BEAT_LAST) begin
				valid_q <= 1'b0;
			end
			cnt_q <= cnt_q + 2'd1;
		end
	end

	// quad in output order: local first, local second, far second, far first
	always_ff @(posedge clk) begin
		if (load) begin
			quad_q[0] <= swap ? s3_data.loc1 : s3_data.loc0;
			quad_q[1] <= swap ? s3_data.loc0 : s3_data.loc1;
			quad_q[2] <= swap ? s3_data.far0 : s3_data.far1;
			quad_q[3] <= swap ? s3_data.far1 : s3_data.far0;
		end
	end

	assign beat        = quad_q[cnt_q];
	assign out_valid   = valid_q;
	assign out_x       = beat.x;
	assign out_y       = beat.y;
	assign out_z       = beat.z;
	assign finite      = (cnt_q < BEAT_FIRST_FAR);
	assign last_of_run = (cnt_q == BEAT_LAST);

	a_hold_has_edge: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> s3_ctl.valid)
		else $error("pipeline held without a silhouette edge waiting");

	a_quad_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_run) |=> out_valid)
		else $error("quad ended before its fourth vertex");

	a_quad_starts_local: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_run) |=> (!out_valid || finite))
		else $error("next quad does not start with a local vertex");

endmodule

`default_nettype wire
